@@ hdl/hll_pkg.sv @@
// Shared constants, codes and result type of the HyperLogLog cardinality estimator.
package hll_pkg;

	localparam int HASH_W = 32;
	localparam int RANK_W = 5;
	localparam int EMPTY_W = 11;

	// Reset value of the alpha*m*m register, unsigned 32.32
	localparam logic [63:0] ALPHA_RESET = 64'd3245027107012608;
	// Large-range threshold, 143165576.533 truncated to 32.32
	localparam logic [63:0] LARGE_THR = {32'd143165576, 32'd2289217568};

	// Command codes
	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_EST = 1'b1;

	// Range codes
	localparam logic [1:0] RANGE_RAW = 2'd0;
	localparam logic [1:0] RANGE_LINEAR = 2'd1;
	localparam logic [1:0] RANGE_LARGE = 2'd2;

	typedef struct packed {
		logic [63:0] estimate;
		logic [1:0] range_used;
		logic [EMPTY_W-1:0] empty_buckets;
	} hll_result_t;

endpackage

@@ hdl/hll_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module hll_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read (old data on a same-address write)
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/hll_front.sv @@
// Front end: accepts words, splits a hash into bucket index and rank, queues them.
module hll_front import hll_pkg::*; #(
	parameter int INDEX_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  command,
	input  logic [HASH_W-1:0]     hash,
	input  logic                  clearing,
	output logic                  busy,
	input  logic                  pop,
	output logic                  head_valid,
	output logic                  head_est,
	output logic [INDEX_BITS-1:0] head_idx,
	output logic [RANK_W-1:0]     head_rank
);

	localparam int FIELD_W = HASH_W - INDEX_BITS;
	localparam int DEPTH = 4;
	localparam int PTR_W = 2;
	localparam int CNT_W = 3;

	logic                  est_q  [DEPTH];
	logic [INDEX_BITS-1:0] idx_q  [DEPTH];
	logic [RANK_W-1:0]     rank_q [DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      count_q;
	logic                  accept;
	logic [FIELD_W-1:0]    field;
	logic [5:0]            lz;
	logic [RANK_W-1:0]     new_rank;

	assign busy = (count_q == CNT_W'(DEPTH)) || clearing;
	assign accept = start && !busy;

	// Count leading zeros of the bits below the index
	assign field = hash[FIELD_W-1:0];
	always_comb begin
		lz = 6'(FIELD_W);
		for (int i = 0; i < FIELD_W; i++) begin
			if (field[i]) begin
				lz = 6'(FIELD_W - 1 - i);
			end
		end
	end
	assign new_rank = RANK_W'(lz) + RANK_W'(1);

	// Store the classified word
	always_ff @(posedge clk) begin
		if (accept) begin
			est_q[wr_ptr_q] <= command;
			idx_q[wr_ptr_q] <= hash[HASH_W-1:FIELD_W];
			rank_q[wr_ptr_q] <= new_rank;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (accept && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !accept) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign head_valid = (count_q != '0);
	assign head_est = est_q[rd_ptr_q];
	assign head_idx = idx_q[rd_ptr_q];
	assign head_rank = rank_q[rd_ptr_q];

endmodule

@@ hdl/hll_back.sv @@
// Back end: bucket memory clearing, rank update per add, and the bucket sweep.
module hll_back import hll_pkg::*; #(
	parameter int INDEX_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  logic                  head_est,
	input  logic [INDEX_BITS-1:0] head_idx,
	input  logic [RANK_W-1:0]     head_rank,
	output logic                  pop,
	output logic                  clearing,
	output logic                  calc_go,
	output logic [63:0]           calc_sum,
	output logic [INDEX_BITS:0]   calc_zeros,
	input  logic                  calc_done
);

	localparam int CNT_W = INDEX_BITS + 1;

	localparam logic [1:0] B_CLEAR = 2'd0;
	localparam logic [1:0] B_RUN   = 2'd1;
	localparam logic [1:0] B_SWEEP = 2'd2;
	localparam logic [1:0] B_WAIT  = 2'd3;

	logic [1:0]            state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  valid_s1;
	logic [INDEX_BITS-1:0] idx_s1;
	logic [RANK_W-1:0]     rank_s1;
	logic                  fwd_valid_q;
	logic [INDEX_BITS-1:0] fwd_idx_q;
	logic [RANK_W-1:0]     fwd_rank_q;
	logic                  rd_valid_q;
	logic [63:0]           sum_q;
	logic [CNT_W-1:0]      zeros_q;
	logic                  go_q;
	logic                  ram_we;
	logic [INDEX_BITS-1:0] ram_waddr;
	logic [RANK_W-1:0]     ram_wdata;
	logic [INDEX_BITS-1:0] ram_raddr;
	logic [RANK_W-1:0]     ram_rdata;
	logic [RANK_W-1:0]     old_rank;
	logic [RANK_W-1:0]     max_rank;
	logic                  last;
	logic                  issue;

	assign last = (cnt_q[INDEX_BITS-1:0] == {INDEX_BITS{1'b1}});
	assign issue = (state_q == B_SWEEP) && !cnt_q[INDEX_BITS];
	assign pop = (state_q == B_RUN) && head_valid && (head_est == CMD_ADD || !valid_s1);
	assign clearing = (state_q == B_CLEAR);

	// Merge the read rank with the last write, keep the maximum
	assign old_rank = (fwd_valid_q && fwd_idx_q == idx_s1) ? fwd_rank_q : ram_rdata;
	assign max_rank = (rank_s1 > old_rank) ? rank_s1 : old_rank;

	// Memory port selection
	always_comb begin
		if (state_q == B_CLEAR) begin
			ram_we = 1'b1;
			ram_waddr = cnt_q[INDEX_BITS-1:0];
			ram_wdata = '0;
		end else begin
			ram_we = valid_s1;
			ram_waddr = idx_s1;
			ram_wdata = max_rank;
		end
		ram_raddr = (state_q == B_SWEEP) ? cnt_q[INDEX_BITS-1:0] : head_idx;
	end

	hll_ram #(
		.WIDTH(RANK_W),
		.DEPTH(1 << INDEX_BITS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Hold update stage and sweep data
	always_ff @(posedge clk) begin
		if (pop && head_est == CMD_ADD) begin
			idx_s1 <= head_idx;
			rank_s1 <= head_rank;
		end
		if (valid_s1) begin
			fwd_idx_q <= idx_s1;
			fwd_rank_q <= max_rank;
		end
		if (pop && head_est == CMD_EST) begin
			sum_q <= '0;
			zeros_q <= '0;
		end else if (rd_valid_q) begin
			sum_q <= sum_q + (64'd1 << (6'd32 - 6'(ram_rdata)));
			if (ram_rdata == '0) begin
				zeros_q <= zeros_q + CNT_W'(1);
			end
		end
	end

	// Sequence clearing, adds and sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			cnt_q <= '0;
			valid_s1 <= 1'b0;
			fwd_valid_q <= 1'b0;
			rd_valid_q <= 1'b0;
			go_q <= 1'b0;
		end else begin
			go_q <= 1'b0;
			valid_s1 <= pop && head_est == CMD_ADD;
			if (valid_s1) begin
				fwd_valid_q <= 1'b1;
			end
			rd_valid_q <= issue;
			unique case (state_q)
				B_CLEAR: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (last) begin
						cnt_q <= '0;
						state_q <= B_RUN;
					end
				end
				B_RUN: begin
					if (pop && head_est == CMD_EST) begin
						cnt_q <= '0;
						state_q <= B_SWEEP;
					end
				end
				B_SWEEP: begin
					if (issue) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end else if (!rd_valid_q) begin
						go_q <= 1'b1;
						state_q <= B_WAIT;
					end
				end
				B_WAIT: begin
					if (calc_done) begin
						state_q <= B_RUN;
					end
				end
				default: state_q <= B_CLEAR;
			endcase
		end
	end

	assign calc_go = go_q;
	assign calc_sum = sum_q;
	assign calc_zeros = zeros_q;

endmodule

@@ hdl/hll_calc.sv @@
// Estimate arithmetic: shift-subtract divider, split 64x64 multiplier, log series.
module hll_calc import hll_pkg::*; #(
	parameter int INDEX_BITS = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic [63:0]         sum,
	input  logic [INDEX_BITS:0] zeros,
	input  logic [63:0]         alpha,
	output logic                done,
	output hll_result_t         result
);

	localparam int BUCKETS = 1 << INDEX_BITS;
	localparam logic [63:0] SMALL_THR = 64'(BUCKETS * 5) << 31;
	localparam logic [63:0] Q_NUM = 64'd1 << (INDEX_BITS + 32);

	localparam logic [3:0] C_IDLE  = 4'd0;
	localparam logic [3:0] C_RAW   = 4'd1;
	localparam logic [3:0] C_CLASS = 4'd2;
	localparam logic [3:0] C_ATZ   = 4'd3;
	localparam logic [3:0] C_ATZ2  = 4'd4;
	localparam logic [3:0] C_ATMUL = 4'd5;
	localparam logic [3:0] C_ATDIV = 4'd6;
	localparam logic [3:0] C_ATRET = 4'd7;
	localparam logic [3:0] C_QDIV  = 4'd8;
	localparam logic [3:0] C_TOPB  = 4'd9;
	localparam logic [3:0] C_FIN   = 4'd10;
	localparam logic [3:0] C_FIN2  = 4'd11;
	localparam logic [3:0] C_OUT   = 4'd12;

	// Divider
	logic        div_go_q;
	logic [63:0] div_rem0_q;
	logic [63:0] div_num_q;
	logic [63:0] div_den_q;
	logic [6:0]  div_cnt_q;
	logic [6:0]  dcnt_q;
	logic [63:0] dr_q;
	logic [63:0] dn_q;
	logic [63:0] dq_q;
	logic        dovf_q;
	logic [64:0] div_rs;
	logic [64:0] div_diff;
	logic        div_ge;
	logic        div_idle;

	// Multiplier
	logic         mul_go_q;
	logic [63:0]  mul_x_q;
	logic [63:0]  mul_y_q;
	logic [2:0]   mcnt_q;
	logic [63:0]  pp_q;
	logic [1:0]   psh_q;
	logic [127:0] macc_q;
	logic [1:0]   mj;
	logic [31:0]  mxs;
	logic [31:0]  mys;
	logic [127:0] pp_shift;
	logic [63:0]  mres;
	logic         mul_idle;

	// Sequencer
	logic [3:0]           state_q;
	logic [INDEX_BITS:0]  zeros_q;
	logic [63:0]          est_q;
	logic [1:0]           range_q;
	logic                 large_q;
	logic                 phase_q;
	logic [63:0]          n_q;
	logic [5:0]           e_q;
	logic [63:0]          tb_q;
	logic [63:0]          z2_q;
	logic [63:0]          term_q;
	logic [63:0]          acc_q;
	logic [5:0]           k_q;
	logic [63:0]          atr_q;
	logic [63:0]          l2_q;
	logic [63:0]          prod_q;
	logic [5:0]           fac_q;
	logic                 done_q;
	hll_result_t          result_q;
	logic [63:0]          acc_sum;
	logic [63:0]          neg;
	logic [63:0]          lg;

	// Divider step: one quotient bit a cycle
	assign div_rs = {dr_q, dn_q[63]};
	assign div_ge = (div_rs >= {1'b0, div_den_q});
	assign div_diff = div_ge ? (div_rs - {1'b0, div_den_q}) : div_rs;
	assign div_idle = !div_go_q && (dcnt_q == '0);

	always_ff @(posedge clk) begin
		if (div_go_q) begin
			dr_q <= div_rem0_q;
			dn_q <= div_num_q;
			dq_q <= '0;
			dovf_q <= 1'b0;
		end else if (dcnt_q != '0) begin
			dr_q <= div_diff[63:0];
			dn_q <= {dn_q[62:0], 1'b0};
			dq_q <= {dq_q[62:0], div_ge};
			dovf_q <= dovf_q | dq_q[63];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (div_go_q) begin
			dcnt_q <= div_cnt_q;
		end else if (dcnt_q != '0) begin
			dcnt_q <= dcnt_q - 7'd1;
		end
	end

	// Multiplier: four 32x32 partial products, accumulated one a cycle
	assign mj = 2'(3'd5 - mcnt_q);
	assign mxs = mj[1] ? mul_x_q[63:32] : mul_x_q[31:0];
	assign mys = (mj == 2'd1 || mj == 2'd3) ? mul_y_q[63:32] : mul_y_q[31:0];
	assign mul_idle = !mul_go_q && (mcnt_q == '0);
	assign mres = macc_q[125:62];

	always_comb begin
		unique case (psh_q)
			2'd0: pp_shift = {64'd0, pp_q};
			2'd3: pp_shift = {pp_q, 64'd0};
			default: pp_shift = {32'd0, pp_q, 32'd0};
		endcase
	end

	always_ff @(posedge clk) begin
		if (mul_go_q) begin
			macc_q <= '0;
		end else begin
			if (mcnt_q >= 3'd2) begin
				pp_q <= mxs * mys;
				psh_q <= mj;
			end
			if (mcnt_q != '0 && mcnt_q <= 3'd4) begin
				macc_q <= macc_q + pp_shift;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcnt_q <= '0;
		end else if (mul_go_q) begin
			mcnt_q <= 3'd5;
		end else if (mcnt_q != '0) begin
			mcnt_q <= mcnt_q - 3'd1;
		end
	end

	assign acc_sum = acc_q + dq_q;
	assign neg = atr_q >> 4;
	assign lg = (prod_q > neg) ? ((prod_q - neg) >> 26) : 64'd0;

	// Sequence the estimate and its range correction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			div_go_q <= 1'b0;
			mul_go_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			mul_go_q <= 1'b0;
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (go) begin
						zeros_q <= zeros;
						div_go_q <= 1'b1;
						div_rem0_q <= '0;
						div_num_q <= alpha;
						div_den_q <= sum;
						div_cnt_q <= 7'd96;
						state_q <= C_RAW;
					end
				end
				C_RAW: begin
					if (div_idle) begin
						est_q <= dovf_q ? '1 : dq_q;
						state_q <= C_CLASS;
					end
				end
				C_CLASS: begin
					range_q <= RANGE_RAW;
					state_q <= C_OUT;
					if (est_q <= SMALL_THR) begin
						if (zeros_q != '0) begin
							large_q <= 1'b0;
							phase_q <= 1'b0;
							div_go_q <= 1'b1;
							div_rem0_q <= 64'd1;
							div_num_q <= '0;
							div_den_q <= 64'd3;
							div_cnt_q <= 7'd62;
							state_q <= C_ATZ;
						end
					end else if (est_q > LARGE_THR) begin
						large_q <= 1'b1;
						phase_q <= 1'b0;
						n_q <= 64'(33'h1_0000_0000 - {1'b0, est_q[63:32]});
						div_go_q <= 1'b1;
						div_rem0_q <= 64'd1;
						div_num_q <= '0;
						div_den_q <= 64'd3;
						div_cnt_q <= 7'd62;
						state_q <= C_ATZ;
					end
				end
				C_ATZ: begin
					if (div_idle) begin
						acc_q <= dq_q;
						term_q <= dq_q;
						mul_go_q <= 1'b1;
						mul_x_q <= dq_q;
						mul_y_q <= dq_q;
						state_q <= C_ATZ2;
					end
				end
				C_ATZ2: begin
					if (mul_idle) begin
						z2_q <= mres;
						k_q <= 6'd1;
						mul_go_q <= 1'b1;
						mul_x_q <= term_q;
						mul_y_q <= mres;
						state_q <= C_ATMUL;
					end
				end
				C_ATMUL: begin
					if (mul_idle) begin
						if (mres == '0) begin
							atr_q <= acc_q << 1;
							state_q <= C_ATRET;
						end else begin
							term_q <= mres;
							div_go_q <= 1'b1;
							div_rem0_q <= '0;
							div_num_q <= mres;
							div_den_q <= 64'({k_q, 1'b1});
							div_cnt_q <= 7'd64;
							state_q <= C_ATDIV;
						end
					end
				end
				C_ATDIV: begin
					if (div_idle) begin
						acc_q <= acc_sum;
						if (k_q == 6'd63) begin
							atr_q <= acc_sum << 1;
							state_q <= C_ATRET;
						end else begin
							k_q <= k_q + 6'd1;
							mul_go_q <= 1'b1;
							mul_x_q <= term_q;
							mul_y_q <= z2_q;
							state_q <= C_ATMUL;
						end
					end
				end
				C_ATRET: begin
					if (!phase_q) begin
						l2_q <= atr_q >> 4;
						if (large_q) begin
							tb_q <= n_q;
							e_q <= '0;
							state_q <= C_TOPB;
						end else begin
							div_go_q <= 1'b1;
							div_rem0_q <= '0;
							div_num_q <= Q_NUM;
							div_den_q <= 64'(zeros_q);
							div_cnt_q <= 7'd64;
							state_q <= C_QDIV;
						end
					end else begin
						prod_q <= '0;
						tb_q <= l2_q;
						fac_q <= large_q ? (6'd32 - e_q) : (e_q - 6'd32);
						state_q <= C_FIN;
					end
				end
				C_QDIV: begin
					if (div_idle) begin
						n_q <= dq_q;
						tb_q <= dq_q;
						e_q <= '0;
						state_q <= C_TOPB;
					end
				end
				C_TOPB: begin
					if (tb_q[63:1] != '0) begin
						tb_q <= tb_q >> 1;
						e_q <= e_q + 6'd1;
					end else begin
						phase_q <= 1'b1;
						div_go_q <= 1'b1;
						div_rem0_q <= n_q - (64'd1 << e_q);
						div_num_q <= '0;
						div_den_q <= n_q + (64'd1 << e_q);
						div_cnt_q <= 7'd62;
						state_q <= C_ATZ;
					end
				end
				C_FIN: begin
					// Shift-add the small factor times ln 2
					if (fac_q != '0) begin
						if (fac_q[0]) begin
							prod_q <= prod_q + tb_q;
						end
						tb_q <= tb_q << 1;
						fac_q <= fac_q >> 1;
					end else begin
						state_q <= C_FIN2;
					end
				end
				C_FIN2: begin
					if (large_q) begin
						est_q <= (lg[63:32] != '0) ? '1 : {lg[31:0], 32'd0};
						range_q <= RANGE_LARGE;
					end else begin
						est_q <= ((prod_q + neg) >> 26) << INDEX_BITS;
						range_q <= RANGE_LINEAR;
					end
					state_q <= C_OUT;
				end
				C_OUT: begin
					result_q.estimate <= est_q;
					result_q.range_used <= range_q;
					result_q.empty_buckets <= EMPTY_W'(zeros_q);
					done_q <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule

@@ hdl/hyperloglog_cardinality.sv @@
// HyperLogLog cardinality estimator, top level.
// Add: one word a cycle while busy is low; queue, update stage, then the bucket write.
// Estimate: one sweep over the 2^INDEX_BITS buckets, a divide, then for a linear or
// large range log series (up to about 63 multiply and divide rounds each, twice).
// Reset clears the bucket memory, with busy high meanwhile.
// Results are shown on done for one cycle; the receiver cannot stall them.
module hyperloglog_cardinality import hll_pkg::*; #(
	parameter int INDEX_BITS = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                command,
	input  logic [HASH_W-1:0]   hash,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [63:0]         cfg_data,
	output logic                done,
	output logic [63:0]         estimate,
	output logic [EMPTY_W-1:0]  empty_buckets,
	output logic [1:0]          range_used
);

	logic                  clearing;
	logic                  pop;
	logic                  head_valid;
	logic                  head_est;
	logic [INDEX_BITS-1:0] head_idx;
	logic [RANK_W-1:0]     head_rank;
	logic                  calc_go;
	logic [63:0]           calc_sum;
	logic [INDEX_BITS:0]   calc_zeros;
	logic                  calc_done;
	logic [63:0]           alpha_q;
	hll_result_t           result;

	// Hold the alpha*m*m register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
		end else if (cfg_valid && cfg_ready) begin
			alpha_q <= cfg_data;
		end
	end

	hll_front #(
		.INDEX_BITS(INDEX_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.command    (command),
		.hash       (hash),
		.clearing   (clearing),
		.busy       (busy),
		.pop        (pop),
		.head_valid (head_valid),
		.head_est   (head_est),
		.head_idx   (head_idx),
		.head_rank  (head_rank)
	);

	hll_back #(
		.INDEX_BITS(INDEX_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_est   (head_est),
		.head_idx   (head_idx),
		.head_rank  (head_rank),
		.pop        (pop),
		.clearing   (clearing),
		.calc_go    (calc_go),
		.calc_sum   (calc_sum),
		.calc_zeros (calc_zeros),
		.calc_done  (calc_done)
	);

	hll_calc #(
		.INDEX_BITS(INDEX_BITS)
	) u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (calc_go),
		.sum    (calc_sum),
		.zeros  (calc_zeros),
		.alpha  (alpha_q),
		.done   (calc_done),
		.result (result)
	);

	assign done = calc_done;
	assign estimate = result.estimate;
	assign empty_buckets = result.empty_buckets;
	assign range_used = result.range_used;

endmodule
